FILE: hw/rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and codes for the keyed slot table
// Request and result words, the search token that walks the cell row, the
// commit bundle that updates one slot, and the controller states.
// ----------------------------------------------------------------------------
package kst_pkg;

    // Wide enough for any table size up to 256 slots
    localparam int SLOT_IDX_W = 8;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DUP  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] key;
        logic [31:0] entry_value;
    } kst_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [31:0] found_value;
        logic [3:0]  slot_index;
    } kst_resp_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                  active;
        logic                  match;
        logic [SLOT_IDX_W-1:0] match_idx;
        logic [31:0]           match_value;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
    } kst_tok_t;

    // Slot update broadcast by the controller
    typedef struct packed {
        logic                  wr_en;
        logic                  clr_en;
        logic [SLOT_IDX_W-1:0] idx;
        logic [15:0]           key;
        logic [31:0]           value;
    } kst_commit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } kst_state_t;

endpackage

FILE: hw/rtl/kst_cell.sv
// ----------------------------------------------------------------------------
// kst_cell: one slot of the keyed slot table
// Holds a valid mark, key and value handle. Updates the passing search token
// with the first key match and the first empty slot, and registers it for
// the next cell.
// ----------------------------------------------------------------------------
module kst_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         search_key,
    input  kst_pkg::kst_commit_t commit,
    input  kst_pkg::kst_tok_t   tok_in,
    output kst_pkg::kst_tok_t   tok_out
);

    localparam logic [kst_pkg::SLOT_IDX_W-1:0] MY_IDX = kst_pkg::SLOT_IDX_W'(CELL_IDX);

    logic              valid_reg, valid_next;
    logic [15:0]       key_reg;
    logic [31:0]       value_reg;
    kst_pkg::kst_tok_t tok_reg, tok_next;
    logic              sel;

    assign sel = (commit.idx == MY_IDX);

    // Fold this slot into the token
    always_comb begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.match && valid_reg && key_reg == search_key) begin
            tok_next.match       = 1'b1;
            tok_next.match_idx   = MY_IDX;
            tok_next.match_value = value_reg;
        end
        if (tok_in.active && !tok_in.free && !valid_reg) begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
    end

    // Apply a fill or a free aimed at this slot
    always_comb begin
        valid_next = valid_reg;
        if (commit.wr_en && sel) begin
            valid_next = 1'b1;
        end else if (commit.clr_en && sel) begin
            valid_next = 1'b0;
        end
    end

    // Advance the valid mark and the token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        if (commit.wr_en && sel) begin
            key_reg   <= commit.key;
            value_reg <= commit.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table: fixed table of keyed slots with add, find and remove
// A request launches a search token down a row of slot cells, one cell per
// cycle; the controller then answers and updates at most one slot.
//
//   channel  dir  word        handshake
//   s_       in   kst_req_t   s_valid / s_ready
//   m_       out  kst_resp_t  m_valid / m_ready
//
// Requests: a new request is taken only once the previous token has walked
// the whole cell row and its result word has been loaded for output.
// Reset: aresetn (synchronous, active low) empties every slot at once.
// Stalls: a held result blocks only the answer of the next request; the
// next request is taken while the previous word waits on m_ready.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kst_pkg::kst_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kst_pkg::kst_resp_t m_data
);

    kst_pkg::kst_state_t  state_reg, state_next;
    kst_pkg::kst_tok_t    tok_chain [TABLE_SLOTS+1];
    kst_pkg::kst_tok_t    start_tok_reg, start_tok_next;
    kst_pkg::kst_tok_t    end_tok_reg;
    kst_pkg::kst_req_t    req_reg;
    kst_pkg::kst_resp_t   resp;
    kst_pkg::kst_resp_t   m_data_reg;
    kst_pkg::kst_commit_t commit;
    logic                 m_valid_reg, m_valid_next;
    logic                 s_accept, out_free, capture, respond;
    logic [TABLE_SLOTS:0] tok_act;

    assign s_ready  = (state_reg == kst_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign capture  = (state_reg == kst_pkg::ST_SCAN) && tok_chain[TABLE_SLOTS].active;
    assign respond  = (state_reg == kst_pkg::ST_RESP) && out_free;

    // Launch a fresh token in the cycle after accept, once the key is latched
    always_comb begin
        start_tok_next             = '0;
        start_tok_next.active      = s_accept;
    end

    assign tok_chain[0] = start_tok_reg;

    // Row of slot cells
    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        kst_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .search_key (req_reg.key),
            .commit     (commit),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
    end

    for (genvar j = 0; j <= TABLE_SLOTS; j++) begin : g_act
        assign tok_act[j] = tok_chain[j].active;
    end

    // Decide the answer and the slot update from the finished token
    always_comb begin
        resp   = '0;
        commit = '0;
        commit.key   = req_reg.key;
        commit.value = req_reg.entry_value;
        case (req_reg.req_type)
            kst_pkg::REQ_ADD: begin
                if (end_tok_reg.match) begin
                    resp.status = kst_pkg::STATUS_DUP;
                end else if (!end_tok_reg.free) begin
                    resp.status = kst_pkg::STATUS_FULL;
                end else begin
                    resp.status     = kst_pkg::STATUS_OK;
                    resp.slot_index = end_tok_reg.free_idx[3:0];
                    commit.wr_en    = respond;
                    commit.idx      = end_tok_reg.free_idx;
                end
            end
            kst_pkg::REQ_FIND: begin
                if (end_tok_reg.match) begin
                    resp.status      = kst_pkg::STATUS_OK;
                    resp.hit         = 1'b1;
                    resp.found_value = end_tok_reg.match_value;
                    resp.slot_index  = end_tok_reg.match_idx[3:0];
                end else begin
                    resp.status = kst_pkg::STATUS_MISS;
                end
            end
            kst_pkg::REQ_REMOVE: begin
                if (end_tok_reg.match) begin
                    resp.status     = kst_pkg::STATUS_OK;
                    resp.slot_index = end_tok_reg.match_idx[3:0];
                    commit.clr_en   = respond;
                    commit.idx      = end_tok_reg.match_idx;
                end else begin
                    resp.status = kst_pkg::STATUS_MISS;
                end
            end
            default: begin
                resp = '0;
            end
        endcase
    end

    // Controller next state and output register control
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            kst_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = kst_pkg::ST_SCAN;
                end
            end
            kst_pkg::ST_SCAN: begin
                if (capture) begin
                    state_next = kst_pkg::ST_RESP;
                end
            end
            kst_pkg::ST_RESP: begin
                if (respond) begin
                    m_valid_next = 1'b1;
                    state_next   = kst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kst_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            start_tok_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            start_tok_reg <= start_tok_next;
        end
    end

    // Hold request, captured token and result word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_data;
        end
        if (capture) begin
            end_tok_reg <= tok_chain[TABLE_SLOTS];
        end
        if (respond) begin
            m_data_reg <= resp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // At most one search token in the row at any time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_act))
        else $error("more than one search token in flight");

    // A token leaves the row only while the controller waits for it
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_chain[TABLE_SLOTS].active |-> state_reg == kst_pkg::ST_SCAN)
        else $error("token left the row outside a scan");

    // Fill and free never target a slot in the same cycle
    a_commit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(commit.wr_en && commit.clr_en))
        else $error("fill and free in one cycle");

    // Updates land inside the table
    a_commit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit.wr_en || commit.clr_en) |-> (int'(commit.idx) < TABLE_SLOTS))
        else $error("slot update beyond the table");

    // A new result word is loaded only when the output stage is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("held result word overwritten");

endmodule
